// ===== sv/crp_pkg.sv =====
`default_nettype none
package crp_pkg;

  localparam int PROCESSES_DEF    = 4;
  localparam int MAX_FRAMES_DEF   = 8;
  localparam int TOTAL_FRAMES_DEF = 64;
  localparam int PAGES_DEF        = 1024;

  localparam int CMD_W      = 3;
  localparam int PROC_W     = 2;
  localparam int PAGE_W     = 10;
  localparam int FRAME_W    = 6;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int FPP_W      = 4;
  localparam int TF_W       = 7;
  localparam int MAP_WORD   = 8;

  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUSPEND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_FPP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TF   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PROC_W-1:0]  process;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_number;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_out;
    logic                writeback;
    logic [PAGE_W-1:0]   writeback_page;
    logic [FRAME_W-1:0]  writeback_frame;
    logic                last;
  } out_res_t;

  function automatic out_res_t make_res(logic [STATUS_W-1:0] st, logic [FRAME_W-1:0] fr,
                                        logic wb, logic [PAGE_W-1:0] wpage,
                                        logic [FRAME_W-1:0] wframe, logic lst);
    out_res_t r;
    r.status          = st;
    r.frame_out       = fr;
    r.writeback       = wb;
    r.writeback_page  = wpage;
    r.writeback_frame = wframe;
    r.last            = lst;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/crp_ram.sv =====
`default_nettype none
module crp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/clock_page_replacement_core.sv =====
// Clock / enhanced-clock page replacement engine.
// Input channel in_valid/in_stall/in_data carries one request (command, process,
// page, frame). Result channel out_valid/out_stall/out_data returns results;
// the final result of a request has last set. Config port cfg_valid/cfg_ready
// (always ready) writes frames_per_process, replacement_mode, total_frames;
// write only while the block is idle.
// One request is processed at a time. Resident-set walks read the slot RAM
// (registered read): a lookup passes S_LRD and S_LCHK per slot, a free-frame
// search S_MRD and S_MCHK per 8-frame map word, a clock step S_VRD and S_VCHK,
// a suspend or release S_FRD, S_FMAP and S_FWR per resident slot.
// After reset the frame map is cleared, one word per cycle, over all
// ceil(TOTAL_FRAMES / 8) words; in_stall stays high meanwhile.
// A stalled result holds in the output register; the block stalls its input
// until the pending request's results are all taken into that register.
`default_nettype none
module clock_page_replacement_core import crp_pkg::*; #(
  parameter int PROCESSES              = PROCESSES_DEF,
  parameter int MAX_FRAMES_PER_PROCESS = MAX_FRAMES_DEF,
  parameter int TOTAL_FRAMES           = TOTAL_FRAMES_DEF,
  parameter int PAGES_PER_PROCESS      = PAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_req_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_res_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MAXF   = MAX_FRAMES_PER_PROCESS;
  localparam int SLOTS  = PROCESSES * MAXF;
  localparam int SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = $clog2(MAXF + 1);
  localparam int HAND_W = (MAXF > 1) ? $clog2(MAXF) : 1;
  localparam int PIDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int SF_W   = (TOTAL_FRAMES > 1) ? $clog2(TOTAL_FRAMES) : 1;
  localparam int SLOT_W = PAGE_W + SF_W + 2;
  localparam int FMW    = (TOTAL_FRAMES + MAP_WORD - 1) / MAP_WORD;
  localparam int MW_W   = (FMW > 1) ? $clog2(FMW) : 1;
  localparam int JW     = $clog2(MAP_WORD);

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_DEC  = 14'b00000000000100,
    S_HMOD = 14'b00000000001000,
    S_LRD  = 14'b00000000010000,
    S_LCHK = 14'b00000000100000,
    S_MRD  = 14'b00000001000000,
    S_MCHK = 14'b00000010000000,
    S_VRD  = 14'b00000100000000,
    S_VCHK = 14'b00001000000000,
    S_FRD  = 14'b00010000000000,
    S_FMAP = 14'b00100000000000,
    S_FWR  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  in_req_t req_r, req_nxt;
  logic [FPP_W-1:0] fpp_r;
  logic mode_r;
  logic [TF_W-1:0] tf_r;
  logic [IDX_W-1:0] count_r [PROCESSES];
  logic [HAND_W-1:0] hand_r [PROCESSES];
  logic [IDX_W-1:0] n_r, n_nxt, idx_r, idx_nxt, step_r, step_nxt;
  logic [1:0] round_r, round_nxt;
  logic [MW_W-1:0] word_r, word_nxt, clr_r;
  logic pend_valid_r, pend_valid_nxt;
  logic [PAGE_W-1:0] pend_page_r, pend_page_nxt;
  logic [FRAME_W-1:0] pend_frame_r, pend_frame_nxt;
  out_res_t res_r, res_nxt, out_r, out_load_data;
  logic out_valid_r, out_load, out_free;

  logic [PIDX_W-1:0] pidx;
  logic [SA_W-1:0] slot_addr;
  logic slot_we;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;
  logic map_we;
  logic [MW_W-1:0] map_waddr;
  logic [MAP_WORD-1:0] map_wdata, map_rdata;
  logic cnt_we, hand_we;
  logic [IDX_W-1:0] cnt_wdata;
  logic [HAND_W-1:0] hand_wdata;

  logic [PAGE_W-1:0] sl_page;
  logic [SF_W-1:0] sl_frame;
  logic sl_use, sl_dirty;
  int lim, usable;
  logic [MAP_WORD-1:0] free_bits;
  logic found;
  logic [JW-1:0] found_j;
  logic [IDX_W-1:0] idx_inc, hand_adv;
  logic vhit, vclr, match, emit_mid;
  logic [JW-1:0] fbit;

  assign pidx      = req_r.process[PIDX_W-1:0];
  assign slot_addr = SA_W'(SA_W'(pidx) * SA_W'(MAXF) + SA_W'(idx_r));
  assign sl_page   = slot_rdata[SLOT_W-1 -: PAGE_W];
  assign sl_frame  = slot_rdata[2 +: SF_W];
  assign sl_use    = slot_rdata[1];
  assign sl_dirty  = slot_rdata[0];
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign idx_inc   = IDX_W'(idx_r + 1'b1);
  assign hand_adv  = (idx_inc == n_r) ? '0 : idx_inc;
  assign fbit      = JW'(32'(sl_frame) % MAP_WORD);

  crp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_addr), .wdata(slot_wdata),
    .raddr(slot_addr), .rdata(slot_rdata)
  );

  // map read follows the next word so the data lines up with the following state
  crp_ram #(.WIDTH(MAP_WORD), .DEPTH(FMW)) u_map_ram (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(word_nxt), .rdata(map_rdata)
  );

  always_comb begin
    lim = (fpp_r == '0) ? 1 : ((int'(fpp_r) > MAXF) ? MAXF : int'(fpp_r));
    usable = (int'(tf_r) < TOTAL_FRAMES) ? int'(tf_r) : TOTAL_FRAMES;
    for (int j = 0; j < MAP_WORD; j++) begin
      free_bits[j] = !map_rdata[j] && ((int'(word_r) * MAP_WORD + j) < usable);
    end
    found   = 1'b0;
    found_j = '0;
    for (int j = MAP_WORD - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        found   = 1'b1;
        found_j = JW'(j);
      end
    end
    vhit = mode_r ? (!sl_use && (sl_dirty == round_r[0])) : !sl_use;
    vclr = mode_r ? (round_r[0] && sl_use) : sl_use;
    if (req_r.command == CMD_TRANSLATE) begin
      match = (sl_page == req_r.page_number);
    end else begin
      match = (32'(sl_frame) == 32'(req_r.frame_number));
    end
    emit_mid = sl_dirty && pend_valid_r && (req_r.command == CMD_SUSPEND);
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    round_nxt      = round_r;
    word_nxt       = word_r;
    pend_valid_nxt = pend_valid_r;
    pend_page_nxt  = pend_page_r;
    pend_frame_nxt = pend_frame_r;
    res_nxt        = res_r;
    slot_we        = 1'b0;
    slot_wdata     = slot_rdata;
    map_we         = 1'b0;
    map_waddr      = word_r;
    map_wdata      = '0;
    cnt_we         = 1'b0;
    cnt_wdata      = '0;
    hand_we        = 1'b0;
    hand_wdata     = '0;
    out_load       = 1'b0;
    out_load_data  = res_r;
    unique case (state_r)
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        if (32'(clr_r) == FMW - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        n_nxt   = count_r[pidx];
        idx_nxt = '0;
        word_nxt = '0;
        pend_valid_nxt = 1'b0;
        if (req_r.command > CMD_RELEASE) begin
          res_nxt   = make_res(ST_DONE, '0, 1'b0, '0, '0, 1'b1);
          state_nxt = S_OUT;
        end else if (32'(req_r.process) >= PROCESSES) begin
          res_nxt   = make_res(ST_UNKNOWN, '0, 1'b0, '0, '0, 1'b1);
          state_nxt = S_OUT;
        end else if (req_r.command == CMD_TRANSLATE) begin
          if (32'(req_r.page_number) >= PAGES_PER_PROCESS) begin
            res_nxt   = make_res(ST_UNKNOWN, '0, 1'b0, '0, '0, 1'b1);
            state_nxt = S_OUT;
          end else if (count_r[pidx] == '0) begin
            state_nxt = S_MRD;
          end else begin
            state_nxt = S_LRD;
          end
        end else if (req_r.command == CMD_READ || req_r.command == CMD_WRITE) begin
          if (count_r[pidx] == '0) begin
            res_nxt   = make_res(ST_UNKNOWN, req_r.frame_number, 1'b0, '0, '0, 1'b1);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_LRD;
          end
        end else begin
          if (count_r[pidx] == '0) begin
            cnt_we    = 1'b1;
            hand_we   = 1'b1;
            res_nxt   = make_res(ST_DONE, '0, 1'b0, '0, '0, 1'b1);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_LRD: state_nxt = S_LCHK;
      S_LCHK: begin
        if (match) begin
          slot_we       = 1'b1;
          slot_wdata[1] = 1'b1;
          if (req_r.command == CMD_WRITE) slot_wdata[0] = 1'b1;
          if (req_r.command == CMD_TRANSLATE) begin
            res_nxt = make_res(ST_HIT, FRAME_W'(sl_frame), 1'b0, '0, '0, 1'b1);
          end else begin
            res_nxt = make_res(ST_HIT, req_r.frame_number, 1'b0, '0, '0, 1'b1);
          end
          state_nxt = S_OUT;
        end else if (idx_inc == n_r) begin
          if (req_r.command != CMD_TRANSLATE) begin
            res_nxt   = make_res(ST_UNKNOWN, req_r.frame_number, 1'b0, '0, '0, 1'b1);
            state_nxt = S_OUT;
          end else if (int'(n_r) < lim) begin
            idx_nxt   = n_r;
            state_nxt = S_MRD;
          end else begin
            idx_nxt   = IDX_W'(hand_r[pidx]);
            state_nxt = S_HMOD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_LRD;
        end
      end
      S_HMOD: begin
        if (idx_r >= n_r) begin
          idx_nxt = IDX_W'(idx_r - n_r);
        end else begin
          step_nxt  = '0;
          round_nxt = '0;
          state_nxt = S_VRD;
        end
      end
      S_VRD: state_nxt = S_VCHK;
      S_VCHK: begin
        if (vhit) begin
          slot_we    = 1'b1;
          slot_wdata = {req_r.page_number, sl_frame, 1'b1, 1'b0};
          hand_we    = 1'b1;
          hand_wdata = HAND_W'(hand_adv);
          res_nxt    = make_res(ST_REPLACED, FRAME_W'(sl_frame), sl_dirty, sl_page,
                                FRAME_W'(sl_frame), 1'b1);
          state_nxt  = S_OUT;
        end else begin
          if (vclr) begin
            slot_we       = 1'b1;
            slot_wdata[1] = 1'b0;
          end
          idx_nxt = hand_adv;
          if (IDX_W'(step_r + 1'b1) == n_r) begin
            step_nxt  = '0;
            round_nxt = round_r + 2'd1;
          end else begin
            step_nxt = IDX_W'(step_r + 1'b1);
          end
          state_nxt = S_VRD;
        end
      end
      S_MRD: state_nxt = S_MCHK;
      S_MCHK: begin
        if (found) begin
          map_we     = 1'b1;
          map_wdata  = map_rdata | (MAP_WORD'(1) << found_j);
          slot_we    = 1'b1;
          slot_wdata = {req_r.page_number,
                        SF_W'(32'(word_r) * MAP_WORD + 32'(found_j)), 1'b1, 1'b0};
          cnt_we     = 1'b1;
          cnt_wdata  = IDX_W'(n_r + 1'b1);
          res_nxt    = make_res(ST_FAULT,
                                FRAME_W'(32'(word_r) * MAP_WORD + 32'(found_j)),
                                1'b0, '0, '0, 1'b1);
          state_nxt  = S_OUT;
        end else if ((int'(word_r) + 1) * MAP_WORD >= usable || 32'(word_r) == FMW - 1) begin
          res_nxt   = make_res(ST_NO_FRAME, '0, 1'b0, '0, '0, 1'b1);
          state_nxt = S_OUT;
        end else begin
          word_nxt  = MW_W'(word_r + 1'b1);
          state_nxt = S_MRD;
        end
      end
      S_FRD: state_nxt = S_FMAP;
      S_FMAP: begin
        word_nxt  = MW_W'(32'(sl_frame) / MAP_WORD);
        state_nxt = S_FWR;
      end
      S_FWR: begin
        if (!emit_mid || out_free) begin
          map_we    = 1'b1;
          map_wdata = map_rdata & ~(MAP_WORD'(1) << fbit);
          if (emit_mid) begin
            out_load      = 1'b1;
            out_load_data = make_res(ST_DONE, '0, 1'b1, pend_page_r, pend_frame_r, 1'b0);
          end
          if (sl_dirty && req_r.command == CMD_SUSPEND) begin
            pend_valid_nxt = 1'b1;
            pend_page_nxt  = sl_page;
            pend_frame_nxt = FRAME_W'(sl_frame);
          end
          if (idx_inc == n_r) begin
            cnt_we  = 1'b1;
            hand_we = 1'b1;
            if (pend_valid_nxt) begin
              res_nxt = make_res(ST_DONE, '0, 1'b1, pend_page_nxt, pend_frame_nxt, 1'b1);
            end else begin
              res_nxt = make_res(ST_DONE, '0, 1'b0, '0, '0, 1'b1);
            end
            state_nxt = S_OUT;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_FRD;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      fpp_r       <= FPP_W'(4);
      mode_r      <= 1'b0;
      tf_r        <= TF_W'(64);
      out_valid_r <= 1'b0;
      for (int p = 0; p < PROCESSES; p++) begin
        count_r[p] <= '0;
        hand_r[p]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= MW_W'(clr_r + 1'b1);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FPP:  fpp_r  <= cfg_data[FPP_W-1:0];
          CFG_MODE: mode_r <= cfg_data[0];
          CFG_TF:   tf_r   <= cfg_data[TF_W-1:0];
          default: ;
        endcase
      end
      if (cnt_we) count_r[pidx] <= cnt_wdata;
      if (hand_we) hand_r[pidx] <= hand_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    step_r       <= step_nxt;
    round_r      <= round_nxt;
    word_r       <= word_nxt;
    pend_valid_r <= pend_valid_nxt;
    pend_page_r  <= pend_page_nxt;
    pend_frame_r <= pend_frame_nxt;
    res_r        <= res_nxt;
    if (out_load) out_r <= out_load_data;
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DEC)
    else $error("accepted request did not start decode");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEC |-> int'(count_r[pidx]) <= MAXF)
    else $error("resident count beyond limit");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LCHK || state_r == S_VCHK || state_r == S_FWR) |-> idx_r < n_r)
    else $error("slot walk index out of resident set");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
  import crp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPROC  = PROCESSES_DEF;
  localparam int NSLOT  = MAX_FRAMES_DEF;
  localparam int NFRAME = TOTAL_FRAMES_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_res_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  clock_page_replacement_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block
  logic [3:0] mdl_fpp;
  logic       mdl_mode;
  logic [6:0] mdl_tf;
  logic       frame_busy [NFRAME];
  logic [PAGE_W-1:0]  slot_pg  [NPROC*NSLOT];
  logic [FRAME_W-1:0] slot_fr  [NPROC*NSLOT];
  logic               slot_use [NPROC*NSLOT];
  logic               slot_dty [NPROC*NSLOT];
  int resident [NPROC];
  int hand_pos [NPROC];

  in_req_t  pending_reqs [$];
  out_res_t expected_res [$];
  int n_req, n_res, n_bad;
  int status_seen [8];
  bit quiet;
  bit timed_out;

  function automatic out_res_t res(logic [2:0] st, logic [5:0] fr, logic wb,
                                   logic [9:0] wp, logic [5:0] wf, logic lst);
    out_res_t r;
    r.status = st; r.frame_out = fr; r.writeback = wb;
    r.writeback_page = wp; r.writeback_frame = wf; r.last = lst;
    return r;
  endfunction

  function automatic void clear_set(int p);
    for (int i = 0; i < resident[p]; i++) begin
      frame_busy[slot_fr[p*NSLOT+i]] = 1'b0;
      slot_use[p*NSLOT+i] = 1'b0;
      slot_dty[p*NSLOT+i] = 1'b0;
    end
    resident[p] = 0;
    hand_pos[p] = 0;
  endfunction

  function automatic int clock_victim(int p, int n);
    int b, h, s;
    b = p * NSLOT;
    h = hand_pos[p] % n;
    if (!mdl_mode) begin
      for (int i = 0; i < 2*n; i++) begin
        s = h;
        h = (h + 1) % n;
        if (!slot_use[b+s]) begin
          hand_pos[p] = h;
          return s;
        end
        slot_use[b+s] = 1'b0;
      end
    end else begin
      for (int rd = 0; rd < 4; rd++) begin
        for (int i = 0; i < n; i++) begin
          s = h;
          h = (h + 1) % n;
          if (!slot_use[b+s] && slot_dty[b+s] == rd[0]) begin
            hand_pos[p] = h;
            return s;
          end
          if (rd[0]) slot_use[b+s] = 1'b0;
        end
      end
    end
    hand_pos[p] = h;
    return 0;
  endfunction

  function automatic void predict_request(in_req_t r);
    int p, b, n, lim, usable, s, k;
    logic [9:0] vp;
    logic [5:0] vf;
    logic vd;
    p = r.process;
    b = p * NSLOT;
    n = resident[p];
    if (r.command > CMD_RELEASE) begin
      expected_res.push_back(res(ST_DONE, 0, 0, 0, 0, 1));
      return;
    end
    case (r.command)
      CMD_TRANSLATE: begin
        for (int i = 0; i < n; i++)
          if (slot_pg[b+i] == r.page_number) begin
            slot_use[b+i] = 1'b1;
            expected_res.push_back(res(ST_HIT, slot_fr[b+i], 0, 0, 0, 1));
            return;
          end
        lim = (mdl_fpp < 1) ? 1 : (mdl_fpp > NSLOT) ? NSLOT : mdl_fpp;
        if (n < lim) begin
          usable = (mdl_tf < NFRAME) ? mdl_tf : NFRAME;
          for (int i = 0; i < usable; i++)
            if (!frame_busy[i]) begin
              frame_busy[i] = 1'b1;
              slot_pg[b+n] = r.page_number;
              slot_fr[b+n] = i[5:0];
              slot_use[b+n] = 1'b1;
              slot_dty[b+n] = 1'b0;
              resident[p] = n + 1;
              expected_res.push_back(res(ST_FAULT, i[5:0], 0, 0, 0, 1));
              return;
            end
          expected_res.push_back(res(ST_NO_FRAME, 0, 0, 0, 0, 1));
          return;
        end
        s = clock_victim(p, n);
        vp = slot_pg[b+s];
        vf = slot_fr[b+s];
        vd = slot_dty[b+s];
        slot_pg[b+s] = r.page_number;
        slot_use[b+s] = 1'b1;
        slot_dty[b+s] = 1'b0;
        frame_busy[vf] = 1'b1;
        expected_res.push_back(res(ST_REPLACED, vf, vd, vp, vf, 1));
      end
      CMD_READ, CMD_WRITE: begin
        for (int i = 0; i < n; i++)
          if (slot_fr[b+i] == r.frame_number) begin
            slot_use[b+i] = 1'b1;
            if (r.command == CMD_WRITE) slot_dty[b+i] = 1'b1;
            expected_res.push_back(res(ST_HIT, r.frame_number, 0, 0, 0, 1));
            return;
          end
        expected_res.push_back(res(ST_UNKNOWN, r.frame_number, 0, 0, 0, 1));
      end
      CMD_SUSPEND: begin
        k = 0;
        for (int i = 0; i < n; i++)
          if (slot_dty[b+i]) begin
            expected_res.push_back(res(ST_DONE, 0, 1, slot_pg[b+i], slot_fr[b+i], 0));
            k++;
          end
        clear_set(p);
        if (k == 0) expected_res.push_back(res(ST_DONE, 0, 0, 0, 0, 1));
        else expected_res[$].last = 1'b1;
      end
      default: begin
        clear_set(p);
        expected_res.push_back(res(ST_DONE, 0, 0, 0, 0, 1));
      end
    endcase
  endfunction

  // request driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(in_data);
        n_req++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  int out_gap;
  bit long_hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_res++;
        status_seen[out_data.status]++;
        if (expected_res.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_res_t w;
          w = expected_res.pop_front();
          if (out_data.status !== w.status || out_data.frame_out !== w.frame_out ||
              out_data.writeback !== w.writeback ||
              out_data.writeback_page !== w.writeback_page ||
              out_data.writeback_frame !== w.writeback_frame ||
              out_data.last !== w.last) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch at result %0d: expected %p, got %p", n_res, w, out_data);
          end
        end
      end
      if (!long_hold_done && n_res == 60) begin
        long_hold_done = 1;
        out_gap = 300;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FPP:  mdl_fpp = val[3:0];
      CFG_MODE: mdl_mode = val[0];
      default:  mdl_tf = val[6:0];
    endcase
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while ((pending_reqs.size() > 0 || in_valid || expected_res.size() > 0) &&
           guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  function automatic void queue_req(logic [2:0] c, int p, int pg, int fr);
    in_req_t r;
    r.command = c;
    r.process = p[1:0];
    r.page_number = pg[9:0];
    r.frame_number = fr[5:0];
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_random(int cnt);
    int roll;
    logic [2:0] c;
    for (int i = 0; i < cnt; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) c = CMD_TRANSLATE;
      else if (roll < 65) c = CMD_READ;
      else if (roll < 85) c = CMD_WRITE;
      else if (roll < 91) c = CMD_SUSPEND;
      else if (roll < 95) c = CMD_RELEASE;
      else c = 3'($urandom_range(5, 7));
      queue_req(c, $urandom_range(0, 3),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 11),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15));
    end
  endfunction

  int cfg_set [7][3] = '{'{8, 1, 64}, '{1, 0, 1}, '{2, 1, 3}, '{8, 0, 5},
                         '{3, 1, 64}, '{1, 1, 64}, '{5, 0, 20}};

  initial begin
    mdl_fpp = 4; mdl_mode = 0; mdl_tf = 64;
    foreach (frame_busy[i]) frame_busy[i] = 1'b0;
    foreach (slot_use[i]) begin
      slot_use[i] = 1'b0;
      slot_dty[i] = 1'b0;
    end
    foreach (resident[i]) begin
      resident[i] = 0;
      hand_pos[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill, hit, replace clean victim, unknown frame, suspend, release, bad commands
    queue_req(CMD_TRANSLATE, 0, 0, 0);
    queue_req(CMD_TRANSLATE, 0, 1023, 63);
    queue_req(CMD_TRANSLATE, 0, 5, 0);
    queue_req(CMD_TRANSLATE, 0, 7, 0);
    queue_req(CMD_TRANSLATE, 0, 1023, 0);
    queue_req(CMD_WRITE, 0, 0, 1);
    queue_req(CMD_READ, 0, 0, 2);
    queue_req(CMD_READ, 0, 0, 63);
    queue_req(CMD_TRANSLATE, 0, 9, 0);
    queue_req(CMD_TRANSLATE, 3, 682, 0);
    queue_req(CMD_WRITE, 3, 0, 4);
    queue_req(CMD_WRITE, 0, 0, 3);
    queue_req(CMD_SUSPEND, 0, 0, 0);
    queue_req(CMD_SUSPEND, 1, 0, 0);
    queue_req(CMD_RELEASE, 3, 0, 0);
    queue_req(5, 2, 341, 42);
    queue_req(6, 1, 0, 0);
    queue_req(7, 3, 1023, 63);
    queue_random(30);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_FPP, cfg_set[ph][0]);
      write_reg(CFG_MODE, cfg_set[ph][1]);
      write_reg(CFG_TF, cfg_set[ph][2]);
      if (ph == 6) quiet = 1;
      queue_random(50);
      drain();
    end

    $display("tb: %0d requests, %0d results; hit %0d fault %0d replaced %0d", n_req, n_res,
             status_seen[ST_HIT], status_seen[ST_FAULT], status_seen[ST_REPLACED]);
    $display("tb: no-frame %0d unknown %0d done %0d over 8 register settings",
             status_seen[ST_NO_FRAME], status_seen[ST_UNKNOWN], status_seen[ST_DONE]);
    if (n_bad == 0 && expected_res.size() == 0 && !timed_out) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    timed_out = 1;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

// ===== clock_page_replacement_core.f =====
sv/crp_pkg.sv
sv/crp_ram.sv
sv/clock_page_replacement_core.sv
tb/tb.sv
